/* rtl/core/ssf_pkg.sv */
// Shared types, constants and codes for the shortest-seek-first request queue.
`default_nettype none

package ssf_pkg;

	// Geometry
	localparam int QUEUE_DEPTH = 32;
	localparam int SECTOR_BITS = 32;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TAG_W       = 8;
	localparam int HOLD_W      = 8;

	// Configuration port
	localparam int ADDR_W    = 3;
	localparam int CFG_IDX_W = ADDR_W - 2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD = '0;

	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_DISPATCH = 2'd1,
		CMD_REMOVE   = 2'd2
	} ssf_cmd_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_EMPTY    = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_HELD     = 3'd3,
		STAT_NOTFOUND = 3'd4
	} ssf_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH
	} ssf_state_t;

	// Search token handed from cell to cell
	typedef struct packed {
		logic                   has;
		logic [IDX_W-1:0]       idx;
		logic [SECTOR_BITS-1:0] gap;
		logic [SECTOR_BITS-1:0] sector;
		logic [TAG_W-1:0]       tag;
	} ssf_wave_t;

	// Control broadcast from the sequencer to every cell
	typedef struct packed {
		logic                   load;
		logic [IDX_W-1:0]       load_idx;
		logic                   shift;
		logic [IDX_W-1:0]       pos;
		logic                   mode_tag;
		logic [TAG_W-1:0]       req_tag;
		logic [SECTOR_BITS-1:0] last_sector;
		logic [SECTOR_BITS-1:0] new_sector;
		logic [TAG_W-1:0]       new_tag;
	} ssf_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/shortest_seek_first_request_queue.sv */
// An add (or unused command) goes from idle straight to the finish state, which registers the result.
// Dispatch and remove run a search token down the chain of QUEUE_DEPTH slots, one slot
// per cycle, before the finish state registers their result; a busy output stalls it.
// One item at a time; the next beat is taken the cycle after the result is registered.
// Reset (arst_n low, asynchronous): queue empty, last sector and add count zero, hold off.
`default_nettype none

module shortest_seek_first_request_queue import ssf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input beats
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	input  wire logic [39:0]       s_tdata,  // [31:0] sector, [39:32] request_tag
	input  wire logic [1:0]        s_tuser,  // [1:0] cmd
	// result beats
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	output      logic [47:0]       m_tdata,  // [7:0] out_tag, [39:8] out_sector,
	                                         // [40] moved_lower, [47:41] zero
	output      logic [3:0]        m_tuser,  // [2:0] status, [3] dispatched
	// configuration
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output      logic [31:0]       prdata,
	output      logic              pready
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	ssf_state_t state_q, state_d;

	logic [1:0]             cmd_q;
	logic [SECTOR_BITS-1:0] sec_q;
	logic [TAG_W-1:0]       tag_q;
	logic [IDX_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       fill_q;
	logic [SECTOR_BITS-1:0] last_q;
	logic [HOLD_W-1:0]      adds_q;
	logic [HOLD_W-1:0]      hold_add_count;

	logic                   m_valid_q;
	logic [2:0]             status_q;
	logic                   disp_q;
	logic [TAG_W-1:0]       otag_q;
	logic [31:0]            osec_q;
	logic                   lower_q;

	logic                   accept;
	logic                   out_free;
	logic                   commit;
	logic                   held;

	ssf_ctrl_t              ctrl;
	ssf_status_t            status_d;
	logic                   disp_d;
	logic                   add_ok;

	ssf_wave_t              wave [QUEUE_DEPTH];
	logic                   valid_vec [QUEUE_DEPTH];
	logic [SECTOR_BITS-1:0] sec_arr [QUEUE_DEPTH];
	logic [TAG_W-1:0]       tag_arr [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_bits;
	ssf_wave_t              wave_end;

	// Configuration registers
	ssf_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.hold_add_count (hold_add_count)
	);

	// Chain of slots; slot 0 holds the oldest request
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		ssf_wave_t              w_in;
		logic                   n_valid;
		logic [SECTOR_BITS-1:0] n_sector;
		logic [TAG_W-1:0]       n_tag;

		if (g == 0) begin : g_head
			assign w_in = '0;
		end else begin : g_link
			assign w_in = wave[g-1];
		end

		if (g == QUEUE_DEPTH - 1) begin : g_tail
			assign n_valid  = 1'b0;
			assign n_sector = '0;
			assign n_tag    = '0;
		end else begin : g_next
			assign n_valid  = valid_vec[g+1];
			assign n_sector = sec_arr[g+1];
			assign n_tag    = tag_arr[g+1];
		end

		ssf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (IDX_W'(g)),
			.ctrl       (ctrl),
			.wave_in    (w_in),
			.nxt_valid  (n_valid),
			.nxt_sector (n_sector),
			.nxt_tag    (n_tag),
			.valid      (valid_vec[g]),
			.sector     (sec_arr[g]),
			.tag        (tag_arr[g]),
			.wave_out   (wave[g])
		);

		assign valid_bits[g] = valid_vec[g];
	end

	assign wave_end = wave[QUEUE_DEPTH-1];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign commit   = (state_q == S_FINISH) && out_free;
	assign held     = (hold_add_count != '0) && (adds_q < hold_add_count);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if ((s_tuser == CMD_DISPATCH) || (s_tuser == CMD_REMOVE)) begin
						state_d = S_SEARCH;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SEARCH: begin
				if (cnt_q == LAST_IDX) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer: slot control and result
	always_comb begin
		ctrl             = '0;
		ctrl.load_idx    = fill_q[IDX_W-1:0];
		ctrl.pos         = wave_end.idx;
		ctrl.mode_tag    = (cmd_q == CMD_REMOVE);
		ctrl.req_tag     = tag_q;
		ctrl.last_sector = last_q;
		ctrl.new_sector  = sec_q;
		ctrl.new_tag     = tag_q;
		status_d         = STAT_OK;
		disp_d           = 1'b0;
		add_ok           = 1'b0;
		unique case (cmd_q)
			CMD_ADD: begin
				if (fill_q == FULL_CNT) begin
					status_d = STAT_FULL;
				end else begin
					add_ok    = 1'b1;
					ctrl.load = commit;
				end
			end
			CMD_DISPATCH: begin
				if (held) begin
					status_d = STAT_HELD;
				end else if (fill_q == '0) begin
					status_d = STAT_EMPTY;
				end else begin
					disp_d     = 1'b1;
					ctrl.shift = commit;
				end
			end
			CMD_REMOVE: begin
				if (wave_end.has) begin
					ctrl.shift = commit;
				end else begin
					status_d = STAT_NOTFOUND;
				end
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	// Sequencer state and search counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SEARCH) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// Captured input beat
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_tuser;
			sec_q <= SECTOR_BITS'(s_tdata[31:0]);
			tag_q <= s_tdata[39:32];
		end
	end

	// Queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			last_q <= '0;
			adds_q <= '0;
		end else if (commit) begin
			if (add_ok) begin
				fill_q <= fill_q + 1'b1;
				if (adds_q != '1) begin
					adds_q <= adds_q + 1'b1;
				end
			end else if (ctrl.shift) begin
				fill_q <= fill_q - 1'b1;
			end
			if (disp_d) begin
				last_q <= wave_end.sector;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_d;
			disp_q   <= disp_d;
			otag_q   <= disp_d ? wave_end.tag : '0;
			osec_q   <= disp_d ? 32'(wave_end.sector) : '0;
			lower_q  <= disp_d && (wave_end.sector < last_q);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, lower_q, osec_q, otag_q};
	assign m_tuser  = {disp_q, status_q};

	// Checks
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond queue depth");

	a_packed_slots: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_bits) == int'(fill_q))
		else $error("occupied slots disagree with fill count");

	a_dispatch_drop: assert property (@(posedge clk) disable iff (!arst_n)
		commit && disp_d |=> fill_q == $past(fill_q) - 1'b1)
		else $error("dispatch did not remove a slot");

	a_dispatch_hit: assert property (@(posedge clk) disable iff (!arst_n)
		commit && disp_d |-> wave_end.has)
		else $error("dispatch with no candidate slot");

endmodule

`default_nettype wire

/* rtl/core/ssf_cell.sv */
// One queue slot: holds a request and passes the search token on to the next slot.
`default_nettype none

module ssf_cell import ssf_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [IDX_W-1:0]       cell_idx,
	input  wire ssf_ctrl_t              ctrl,
	input  wire ssf_wave_t              wave_in,
	input  wire logic                   nxt_valid,
	input  wire logic [SECTOR_BITS-1:0] nxt_sector,
	input  wire logic [TAG_W-1:0]       nxt_tag,
	output      logic                   valid,
	output      logic [SECTOR_BITS-1:0] sector,
	output      logic [TAG_W-1:0]       tag,
	output      ssf_wave_t              wave_out
);

	logic                   valid_q;
	logic [SECTOR_BITS-1:0] sector_q;
	logic [TAG_W-1:0]       tag_q;
	ssf_wave_t              wave_q;

	logic                   do_load;
	logic                   do_shift;
	logic [SECTOR_BITS-1:0] gap;
	logic                   take;

	assign do_load  = ctrl.load && (cell_idx == ctrl.load_idx);
	assign do_shift = ctrl.shift && (cell_idx >= ctrl.pos);

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (do_load) begin
			valid_q <= 1'b1;
		end else if (do_shift) begin
			valid_q <= nxt_valid;
		end
	end

	// Payload: written on add, pulled from the neighbour on removal
	always_ff @(posedge clk) begin
		if (do_load) begin
			sector_q <= ctrl.new_sector;
			tag_q    <= ctrl.new_tag;
		end else if (do_shift) begin
			sector_q <= nxt_sector;
			tag_q    <= nxt_tag;
		end
	end

	// Seek distance from the last dispatched sector
	assign gap = (ctrl.last_sector >= sector_q) ? (ctrl.last_sector - sector_q)
	                                            : (sector_q - ctrl.last_sector);

	// Take the token on a strictly closer sector, or on the first tag match
	always_comb begin
		if (ctrl.mode_tag) begin
			take = valid_q && !wave_in.has && (tag_q == ctrl.req_tag);
		end else begin
			take = valid_q && (!wave_in.has || (gap < wave_in.gap));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else if (take) begin
			wave_q.has    <= 1'b1;
			wave_q.idx    <= cell_idx;
			wave_q.gap    <= gap;
			wave_q.sector <= sector_q;
			wave_q.tag    <= tag_q;
		end else begin
			wave_q <= wave_in;
		end
	end

	assign valid    = valid_q;
	assign sector   = sector_q;
	assign tag      = tag_q;
	assign wave_out = wave_q;

endmodule

`default_nettype wire

/* rtl/core/ssf_cfg.sv */
// Configuration register block on the APB-style port.
`default_nettype none

module ssf_cfg import ssf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output      logic [31:0]       prdata,
	output      logic              pready,
	output      logic [HOLD_W-1:0] hold_add_count
);

	logic [HOLD_W-1:0]    hold_q;
	logic [CFG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_HOLD)) begin
			hold_q <= pwdata[HOLD_W-1:0];
		end
	end

	// Read back
	always_comb begin
		if (reg_idx == REG_HOLD) begin
			prdata = 32'(hold_q);
		end else begin
			prdata = '0;
		end
	end

	assign hold_add_count = hold_q;

endmodule

`default_nettype wire

/* tb/sv/seek_order_checker.sv */
// Checker for the shortest-seek-first request queue: predicts each result beat and compares it.
`timescale 1ns / 100ps

module seek_order_checker import ssf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [39:0]       s_tdata,  // [31:0] sector, [39:32] request_tag
	input  logic [1:0]        s_tuser,  // [1:0] cmd
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [47:0]       m_tdata,  // [7:0] out_tag, [39:8] out_sector, [40] moved_lower
	input  logic [3:0]        m_tuser,  // [2:0] status, [3] dispatched
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                mismatches,
	output int                outstanding
);

	typedef struct packed {
		ssf_status_t      status;
		logic             dispatched;
		logic [TAG_W-1:0] tag;
		logic [31:0]      sector;
		logic             lower;
	} seek_result_t;

	// Own copy of the queue state
	logic [SECTOR_BITS-1:0] queued_sector [QUEUE_DEPTH];
	logic [TAG_W-1:0]       queued_tag    [QUEUE_DEPTH];
	int                     fill;
	logic [SECTOR_BITS-1:0] head_sector;
	logic [7:0]             adds_seen;
	logic [HOLD_W-1:0]      hold_count;
	seek_result_t           results_due [$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	function automatic void flag(string field, logic [31:0] want, logic [31:0] got);
		$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		mismatches++;
	endfunction

	// Close the gap left by a removed entry, keeping arrival order
	function automatic void drop_entry(int pos);
		for (int i = pos; i + 1 < fill; i++) begin
			queued_sector[i] = queued_sector[i + 1];
			queued_tag[i]    = queued_tag[i + 1];
		end
		fill--;
	endfunction

	function automatic seek_result_t schedule(logic [1:0] cmd, logic [31:0] sector,
			logic [TAG_W-1:0] tag);
		seek_result_t           r;
		int                     best;
		logic [SECTOR_BITS-1:0] best_gap;
		logic [SECTOR_BITS-1:0] gap;
		logic [SECTOR_BITS-1:0] s;
		r = '0;
		r.status = STAT_OK;
		case (cmd)
		CMD_ADD: begin
			if (fill >= QUEUE_DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				queued_sector[fill] = sector;
				queued_tag[fill]    = tag;
				fill++;
				if (adds_seen != 8'hFF)
					adds_seen++;
			end
		end
		CMD_DISPATCH: begin
			// hold wins over empty
			if (hold_count != 0 && adds_seen < hold_count) begin
				r.status = STAT_HELD;
			end else if (fill == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				best     = 0;
				best_gap = '0;
				for (int i = 0; i < fill; i++) begin
					s   = queued_sector[i];
					gap = (head_sector >= s) ? head_sector - s : s - head_sector;
					// strict compare: ties stay with the oldest
					if (i == 0 || gap < best_gap) begin
						best     = i;
						best_gap = gap;
					end
				end
				r.dispatched = 1'b1;
				r.tag        = queued_tag[best];
				r.sector     = queued_sector[best][31:0];
				r.lower      = queued_sector[best] < head_sector;
				head_sector  = queued_sector[best];
				drop_entry(best);
			end
		end
		CMD_REMOVE: begin
			best = -1;
			for (int i = 0; i < fill; i++)
				if (best < 0 && queued_tag[i] == tag)
					best = i;
			if (best < 0)
				r.status = STAT_NOTFOUND;
			else
				drop_entry(best);
		end
		default: ;  // spare code: no effect
		endcase
		return r;
	endfunction

	// Watch the three ports; result beat first, its expectation is already queued
	always @(posedge clk or negedge arst_n) begin : watch
		seek_result_t due;
		if (!arst_n) begin
			fill        = 0;
			head_sector = '0;
			adds_seen   = '0;
			hold_count  = '0;
			results_due.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$display("%0t ns: unexpected result beat, tuser %0h tdata %0h",
						$time, m_tuser, m_tdata);
					mismatches++;
				end else begin
					due = results_due.pop_front();
					if (m_tuser[2:0] !== due.status)
						flag("status", 32'(due.status), 32'(m_tuser[2:0]));
					if (m_tuser[3] !== due.dispatched)
						flag("dispatched", 32'(due.dispatched), 32'(m_tuser[3]));
					if (m_tdata[7:0] !== due.tag)
						flag("out_tag", 32'(due.tag), 32'(m_tdata[7:0]));
					if (m_tdata[39:8] !== due.sector)
						flag("out_sector", due.sector, m_tdata[39:8]);
					if (m_tdata[40] !== due.lower)
						flag("moved_lower", 32'(due.lower), 32'(m_tdata[40]));
					if (m_tdata[47:41] !== '0)
						flag("tdata padding", 0, 32'(m_tdata[47:41]));
				end
			end
			if (s_tvalid && s_tready)
				results_due.push_back(schedule(s_tuser, s_tdata[31:0], s_tdata[39:32]));
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_HOLD)
				hold_count = pwdata[HOLD_W-1:0];
			outstanding <= results_due.size();
		end
	end

endmodule

/* tb/sv/testbench.sv */
// Top of the testbench: clock, reset, request stimulus, result sink and verdict.
`timescale 1ns / 100ps

module testbench;
	import ssf_pkg::*;

	localparam logic [1:0] CMD_SPARE  = 2'd3;        // unused command code
	localparam int         SETTLE     = QUEUE_DEPTH + 4;
	localparam int         IDLE_LIMIT = 1000;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [39:0]       s_tdata;   // [31:0] sector, [39:32] request_tag
	logic [1:0]        s_tuser;   // [1:0] cmd
	logic              m_tvalid;
	logic              m_tready;
	logic [47:0]       m_tdata;   // [7:0] out_tag, [39:8] out_sector, [40] moved_lower
	logic [3:0]        m_tuser;   // [2:0] status, [3] dispatched
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int                mismatches;
	int                outstanding;
	int                idle_cycles;
	int                sink_beats;
	int unsigned       sink_wait;
	logic              sink_steady;
	logic              src_steady;
	logic              finished;
	logic [31:0]       last_sector_sent;

	shortest_seek_first_request_queue uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	seek_order_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Result sink: random back-pressure, with steady stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			sink_wait   = 0;
			sink_beats  = 0;
			sink_steady = 1'b0;
		end else if (m_tready && m_tvalid) begin
			sink_beats++;
			if (sink_beats % 64 == 0)
				sink_steady = ($urandom_range(0, 3) == 0);
			sink_wait = sink_steady ? 0 : $urandom_range(0, 10);
			if (sink_wait != 0)
				m_tready <= 1'b0;
		end else if (!m_tready) begin
			if (sink_wait != 0)
				sink_wait--;
			if (sink_wait == 0)
				m_tready <= 1'b1;
		end
	end

	// Watchdog: too long without any beat
	always @(posedge clk) begin
		if (!arst_n || finished || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("shortest_seek_first_request_queue test failed");
			$finish;
		end
	end

	task automatic send_request(input logic [1:0] cmd, input logic [31:0] sector,
			input logic [7:0] tag);
		int unsigned gap;
		gap = src_steady ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {tag, sector};
		do @(posedge clk); while (!s_tready);
		last_sector_sent = sector;
	endtask

	// Stop sending and wait until every result beat is back
	task automatic drain;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_hold(input logic [HOLD_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_HOLD, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Random requests with the given command weights
	task automatic run_random(input int n, input int add_w, input int disp_w,
			input int rem_w, input int spare_w);
		int unsigned pick;
		logic [1:0]  cmd;
		logic [31:0] sector;
		logic [7:0]  tag;
		for (int k = 0; k < n; k++) begin
			if (k % 64 == 0)
				src_steady = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, add_w + disp_w + rem_w + spare_w - 1);
			if (pick < add_w)
				cmd = CMD_ADD;
			else if (pick < add_w + disp_w)
				cmd = CMD_DISPATCH;
			else if (pick < add_w + disp_w + rem_w)
				cmd = CMD_REMOVE;
			else
				cmd = CMD_SPARE;
			// edge sectors, clustered sectors for ties, near the last one, or anywhere
			case ($urandom_range(0, 7))
			0: sector = '0;
			1: sector = '1;
			2: sector = $urandom_range(0, 63);
			3: sector = last_sector_sent + $urandom_range(0, 31) - 16;
			default: sector = $urandom;
			endcase
			// mostly a small tag pool so that removes find their entry
			tag = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
			                                  : 8'($urandom_range(0, 15));
			send_request(cmd, sector, tag);
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		finished         = 1'b0;
		src_steady       = 1'b0;
		last_sector_sent = '0;
		idle_cycles      = 0;
		s_tvalid         = 1'b0;
		s_tdata          = '0;
		s_tuser          = '0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: hold, empty, not found, spare code, extremes, ties, direction
		write_hold(8'd3);
		send_request(CMD_DISPATCH, 32'h0, 8'h00);          // held on empty queue
		send_request(CMD_REMOVE,   32'h0, 8'h07);          // remove on empty
		send_request(CMD_SPARE,    32'hFFFF_FFFF, 8'hFF);  // ignored
		send_request(CMD_ADD,      32'h0, 8'h00);
		send_request(CMD_ADD,      32'hFFFF_FFFF, 8'hFF);
		send_request(CMD_DISPATCH, 32'h0, 8'h00);          // still held
		send_request(CMD_ADD,      32'h8000_0000, 8'h55);
		send_request(CMD_DISPATCH, 32'h0, 8'h00);          // hold released
		send_request(CMD_ADD,      32'd10, 8'h01);
		send_request(CMD_ADD,      32'd10, 8'h02);         // equal distance, later
		send_request(CMD_DISPATCH, 32'h0, 8'h00);          // tie to the older
		send_request(CMD_REMOVE,   32'h0, 8'h02);
		send_request(CMD_REMOVE,   32'h0, 8'h02);          // gone already
		send_request(CMD_DISPATCH, 32'h0, 8'h00);
		send_request(CMD_ADD,      32'd5, 8'hAA);
		send_request(CMD_DISPATCH, 32'h0, 8'h00);          // moves lower
		send_request(CMD_DISPATCH, 32'h0, 8'h00);
		send_request(CMD_DISPATCH, 32'h0, 8'h00);          // empty
		send_request(CMD_REMOVE,   32'h0, 8'hFF);          // empty
		drain();

		// Maximum hold: fill up, many held dispatches until the count is reached
		write_hold(8'd255);
		run_random(500, 50, 20, 28, 2);
		drain();

		// Hold off, balanced mix
		write_hold(8'd0);
		run_random(900, 40, 35, 22, 3);
		drain();

		// Mid hold, mostly dispatches to empty the queue
		write_hold(8'd128);
		run_random(400, 30, 50, 17, 3);
		drain();

		repeat (SETTLE) @(posedge clk);
		finished = 1'b1;
		if (mismatches == 0 && outstanding == 0)
			$display("shortest_seek_first_request_queue test passed");
		else
			$display("shortest_seek_first_request_queue test failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/ssf_pkg.sv
rtl/core/ssf_cell.sv
rtl/core/ssf_cfg.sv
rtl/core/shortest_seek_first_request_queue.sv
tb/sv/seek_order_checker.sv
tb/sv/testbench.sv
